/* hdl/sssp_pkg.sv */
package sssp_pkg;

    localparam int NODE_BITS    = 6;
    localparam int MAX_VERTICES = 1 << NODE_BITS;
    localparam int VC_BITS      = NODE_BITS + 1;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_BITS    = 24;
    localparam int CMD_BITS     = 2;

    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SOLVE = 2'd2;

    localparam logic [DIST_BITS-1:0] DIST_INF = '1;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] w;
        logic [NODE_BITS-1:0]   b;
        logic [NODE_BITS-1:0]   a;
    } edge_t;

    typedef struct packed {
        logic clear_graph;
        logic add_edge;
        logic solve_start;
        logic sel_start;
        logic sel_run;
        logic settle;
        logic edge_issue;
        logic edge_check;
        logic relax;
        logic res_read;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sel_done;
        logic found;
        logic edges_done;
        logic relax_need;
        logic out_free;
    } ctrl_stat_t;

endpackage

/* hdl/sssp_ctrl.sv */
module sssp_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sssp_pkg::CMD_BITS-1:0]  in_cmd,
    input  sssp_pkg::ctrl_stat_t           stat,
    output sssp_pkg::ctrl_cmd_t            cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SEL_START = 4'd1;
    localparam logic [3:0] ST_SEL       = 4'd2;
    localparam logic [3:0] ST_SETTLE    = 4'd3;
    localparam logic [3:0] ST_EDGE_RD   = 4'd4;
    localparam logic [3:0] ST_EDGE_CHK  = 4'd5;
    localparam logic [3:0] ST_RELAX     = 4'd6;
    localparam logic [3:0] ST_RES_RD    = 4'd7;
    localparam logic [3:0] ST_RES_OUT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.clear_graph = accept && (in_cmd == sssp_pkg::CMD_CLEAR);
                cmd.add_edge    = accept && (in_cmd == sssp_pkg::CMD_ADD);
                cmd.solve_start = accept && (in_cmd == sssp_pkg::CMD_SOLVE);
                if (accept && (in_cmd == sssp_pkg::CMD_SOLVE))
                begin
                    state_next = ST_SEL_START;
                end
            end
            ST_SEL_START:
            begin
                cmd.sel_start = 1'b1;
                state_next    = ST_SEL;
            end
            ST_SEL:
            begin
                cmd.sel_run = 1'b1;
                if (stat.sel_done)
                begin
                    state_next = stat.found ? ST_SETTLE : ST_RES_RD;
                end
            end
            ST_SETTLE:
            begin
                cmd.settle = 1'b1;
                state_next = ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                if (stat.edges_done)
                begin
                    state_next = ST_SEL_START;
                end
                else
                begin
                    cmd.edge_issue = 1'b1;
                    state_next     = ST_EDGE_CHK;
                end
            end
            ST_EDGE_CHK:
            begin
                cmd.edge_check = 1'b1;
                state_next     = stat.relax_need ? ST_RELAX : ST_EDGE_RD;
            end
            ST_RELAX:
            begin
                cmd.relax  = 1'b1;
                state_next = ST_EDGE_RD;
            end
            ST_RES_RD:
            begin
                cmd.res_read = 1'b1;
                state_next   = ST_RES_OUT;
            end
            ST_RES_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/sssp_dpath.sv */
module sssp_dpath
#(
    parameter int MAX_EDGES = sssp_pkg::MAX_EDGES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sssp_pkg::ctrl_cmd_t               cmd,
    output sssp_pkg::ctrl_stat_t              stat,
    input  logic [sssp_pkg::NODE_BITS-1:0]    in_node_a,
    input  logic [sssp_pkg::NODE_BITS-1:0]    in_node_b,
    input  logic [sssp_pkg::WEIGHT_BITS-1:0]  in_weight,
    input  logic [sssp_pkg::VC_BITS-1:0]      in_vertex_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sssp_pkg::DIST_BITS-1:0]    out_distance,
    output logic                              out_reachable,
    output logic [sssp_pkg::NODE_BITS-1:0]    out_predecessor,
    output logic                              out_overflow
);

    localparam int NB     = sssp_pkg::NODE_BITS;
    localparam int NV     = sssp_pkg::MAX_VERTICES;
    localparam int VCW    = sssp_pkg::VC_BITS;
    localparam int DB     = sssp_pkg::DIST_BITS;
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);

    localparam logic [VCW-1:0]    VC_MAX    = VCW'(NV);
    localparam logic [VCW-1:0]    VC_MIN    = VCW'(1);
    localparam logic [ECNT_W-1:0] ECNT_FULL = ECNT_W'(MAX_EDGES);

    sssp_pkg::edge_t edge_mem [MAX_EDGES];
    logic [DB-1:0]   dist_mem [NV];
    logic [NB-1:0]   par_mem  [NV];

    logic [VCW-1:0]    n_reg;
    logic [ECNT_W-1:0] edge_count_reg;
    logic              overflow_reg;
    logic [NV-1:0]     dist_vld_reg;
    logic [NV-1:0]     settled_reg;
    logic [NB-1:0]     tgt_reg;

    logic [VCW-1:0]    vcnt_reg;
    logic              pend_reg;
    logic              found_reg;
    logic [NB-1:0]     sel_idx_reg;
    logic [DB-1:0]     best_d_reg;
    logic [NB-1:0]     best_p_reg;
    logic [NB-1:0]     pick_reg;

    logic [ECNT_W-1:0] ecnt_reg;
    sssp_pkg::edge_t   edge_rd_reg;
    logic [NB-1:0]     to_reg;
    logic [sssp_pkg::WEIGHT_BITS-1:0] w_reg;

    logic [DB-1:0]     dist_rd_reg;
    logic [NB-1:0]     par_rd_reg;
    logic              vld_rd_reg;

    logic              out_valid_reg;
    logic [DB-1:0]     out_dist_reg;
    logic              out_reach_reg;
    logic [NB-1:0]     out_pred_reg;
    logic              out_ovf_reg;

    logic              add_ok;
    logic              src_ok;
    logic              sel_issue;
    logic              cand_take;
    logic              hit_a;
    logic              hit_b;
    logic [NB-1:0]     to_c;
    logic              relax_need;
    logic [DB:0]       sum_wide;
    logic [DB-1:0]     sum_clamp;
    logic [DB-1:0]     cur_dist;
    logic              relax_take;
    logic              rd_en;
    logic [NB-1:0]     rd_addr;
    logic              wr_en;
    logic [NB-1:0]     wr_addr;
    logic [DB-1:0]     wr_dist;
    logic [NB-1:0]     wr_par;
    logic [VCW-1:0]    vc_sat;

    assign add_ok = (in_weight != '0) && ({1'b0, in_node_a} < n_reg)
                    && ({1'b0, in_node_b} < n_reg);
    assign src_ok = ({1'b0, in_node_a} < n_reg);

    assign vc_sat = (in_vertex_count < VC_MIN) ? VC_MIN :
                    (in_vertex_count > VC_MAX) ? VC_MAX : in_vertex_count;

    // vertex selection: one read per cycle, each evaluated in the cycle after its read
    assign sel_issue = cmd.sel_run && (vcnt_reg < n_reg);
    assign cand_take = pend_reg && vld_rd_reg && !settled_reg[sel_idx_reg]
                       && (!found_reg || (dist_rd_reg < best_d_reg)
                           || ((dist_rd_reg == best_d_reg) && (par_rd_reg < best_p_reg)));

    // edge check: which endpoint is the other side of the settled vertex
    assign hit_a      = (edge_rd_reg.a == pick_reg);
    assign hit_b      = (edge_rd_reg.b == pick_reg);
    assign to_c       = hit_a ? edge_rd_reg.b : edge_rd_reg.a;
    assign relax_need = (hit_a || hit_b) && !settled_reg[to_c];

    assign sum_wide   = {1'b0, best_d_reg} + (DB + 1)'(w_reg);
    assign sum_clamp  = (sum_wide >= {1'b0, sssp_pkg::DIST_INF})
                        ? (sssp_pkg::DIST_INF - DB'(1)) : sum_wide[DB-1:0];
    assign cur_dist   = vld_rd_reg ? dist_rd_reg : sssp_pkg::DIST_INF;
    assign relax_take = cmd.relax && (cur_dist > sum_clamp);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = tgt_reg;
        if (sel_issue)
        begin
            rd_en   = 1'b1;
            rd_addr = vcnt_reg[NB-1:0];
        end
        else if (cmd.edge_check && relax_need)
        begin
            rd_en   = 1'b1;
            rd_addr = to_c;
        end
        else if (cmd.res_read)
        begin
            rd_en   = 1'b1;
            rd_addr = tgt_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = to_reg;
        wr_dist = sum_clamp;
        wr_par  = pick_reg;
        if (cmd.solve_start && src_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = in_node_a;
            wr_dist = '0;
            wr_par  = in_node_a;
        end
        else if (relax_take)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_edge && add_ok && (edge_count_reg < ECNT_FULL))
        begin
            edge_mem[edge_count_reg[EIDX_W-1:0]] <= '{w: in_weight, b: in_node_b, a: in_node_a};
        end
        if (cmd.edge_issue)
        begin
            edge_rd_reg <= edge_mem[ecnt_reg[EIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_mem[wr_addr] <= wr_dist;
            par_mem[wr_addr]  <= wr_par;
        end
        if (rd_en)
        begin
            dist_rd_reg <= dist_mem[rd_addr];
            par_rd_reg  <= par_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.solve_start)
        begin
            tgt_reg <= in_node_b;
        end
        if (cand_take)
        begin
            best_d_reg <= dist_rd_reg;
            best_p_reg <= par_rd_reg;
            pick_reg   <= sel_idx_reg;
        end
        if (sel_issue)
        begin
            sel_idx_reg <= vcnt_reg[NB-1:0];
        end
        if (cmd.edge_check)
        begin
            to_reg <= to_c;
            w_reg  <= edge_rd_reg.w;
        end
        if (cmd.out_load)
        begin
            out_reach_reg <= vld_rd_reg;
            out_dist_reg  <= vld_rd_reg ? dist_rd_reg : sssp_pkg::DIST_INF;
            out_pred_reg  <= vld_rd_reg ? par_rd_reg : '0;
            out_ovf_reg   <= overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg          <= VC_MAX;
            edge_count_reg <= '0;
            overflow_reg   <= 1'b0;
            dist_vld_reg   <= '0;
            settled_reg    <= '0;
            vld_rd_reg     <= 1'b0;
            vcnt_reg       <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            ecnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_graph)
            begin
                n_reg          <= vc_sat;
                edge_count_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            if (cmd.add_edge && add_ok)
            begin
                if (edge_count_reg < ECNT_FULL)
                begin
                    edge_count_reg <= edge_count_reg + ECNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end

            if (cmd.solve_start)
            begin
                settled_reg  <= '0;
                dist_vld_reg <= src_ok ? (NV'(1) << in_node_a) : '0;
            end
            else if (relax_take)
            begin
                dist_vld_reg[to_reg] <= 1'b1;
            end
            if (cmd.settle)
            begin
                settled_reg[pick_reg] <= 1'b1;
            end

            if (rd_en)
            begin
                vld_rd_reg <= dist_vld_reg[rd_addr];
            end

            if (cmd.sel_start)
            begin
                vcnt_reg  <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.sel_run)
            begin
                pend_reg <= sel_issue;
                if (sel_issue)
                begin
                    vcnt_reg <= vcnt_reg + VCW'(1);
                end
                if (cand_take)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.settle)
            begin
                ecnt_reg <= '0;
            end
            else if (cmd.edge_issue)
            begin
                ecnt_reg <= ecnt_reg + ECNT_W'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.sel_done   = (vcnt_reg == n_reg) && !pend_reg;
    assign stat.found      = found_reg;
    assign stat.edges_done = (ecnt_reg == edge_count_reg);
    assign stat.relax_need = relax_need;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_distance    = out_dist_reg;
    assign out_reachable   = out_reach_reg;
    assign out_predecessor = out_pred_reg;
    assign out_overflow    = out_ovf_reg;

endmodule

/* hdl/single_source_shortest_path_top.sv */
// Shortest-path engine over an undirected weighted graph of up to 64 vertices. Each input
// item carries a command in tuser: clear (takes vertex_count and empties the edge store),
// add edge (weight zero or an endpoint out of range is ignored, a full store drops the edge
// and sets the sticky overflow flag) and solve (node_a is the source, node_b the target).
// Clear and add edge are accepted back to back. Only solve returns an item: distance (all
// ones when unreachable), reachable, predecessor and overflow. A solve runs Dijkstra
// rounds; each round scans the n vertices in use through the distance memory port,
// settles one vertex and walks all E stored edges through the edge memory port, checking
// each one and relaxing it when it touches the settled vertex and its far end is unsettled.
// No clearing pass is needed after reset: distance entries carry valid bits cleared at
// solve start.
module single_source_shortest_path_top
#(
    parameter int MAX_EDGES = sssp_pkg::MAX_EDGES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // node_a, node_b, weight, vertex_count, zero pad
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // distance, reachable, predecessor, overflow
);

    sssp_pkg::ctrl_cmd_t  cmd;
    sssp_pkg::ctrl_stat_t stat;

    logic [sssp_pkg::DIST_BITS-1:0] distance;
    logic                           reachable;
    logic [sssp_pkg::NODE_BITS-1:0] predecessor;
    logic                           overflow;

    sssp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    sssp_dpath #(.MAX_EDGES(MAX_EDGES)) u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_node_a       (s_axis_tdata[5:0]),
        .in_node_b       (s_axis_tdata[11:6]),
        .in_weight       (s_axis_tdata[27:12]),
        .in_vertex_count (s_axis_tdata[34:28]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_distance    (distance),
        .out_reachable   (reachable),
        .out_predecessor (predecessor),
        .out_overflow    (overflow)
    );

    assign m_axis_tdata = {overflow, predecessor, reachable, distance};

endmodule

/* sim/sssp_checker.sv */
`timescale 1ns / 1ps

module sssp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // node_a, node_b, weight, vertex_count, zero pad
    input  logic [1:0]  s_axis_tuser,   // cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // distance, reachable, predecessor, overflow
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          reached_seen,
    output int          overflow_seen
);

    localparam int DIST_BITS    = sssp_pkg::DIST_BITS;
    localparam int NODE_BITS    = sssp_pkg::NODE_BITS;
    localparam int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS;
    localparam int VC_BITS      = sssp_pkg::VC_BITS;
    localparam int MAX_VERTICES = sssp_pkg::MAX_VERTICES;
    localparam int MAX_EDGES    = sssp_pkg::MAX_EDGES;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 reachable;
        logic [NODE_BITS-1:0] predecessor;
        logic                 overflow;
    } path_answer_t;

    path_answer_t    answer_queue[$];
    sssp_pkg::edge_t edge_list [MAX_EDGES];
    int unsigned     edge_total = 0;
    int unsigned     live_vertices = MAX_VERTICES;
    logic            edge_dropped = 1'b0;

    int fails = 0;
    int queued = 0;
    int answered = 0;
    int reached = 0;
    int flagged = 0;

    assign fail_count    = fails;
    assign pending       = queued;
    assign results_seen  = answered;
    assign reached_seen  = reached;
    assign overflow_seen = flagged;

    // dijkstra over the stored edges, settling by distance, then parent, then index
    function automatic path_answer_t shortest_path(input logic [NODE_BITS-1:0] src,
                                                   input logic [NODE_BITS-1:0] dst);
        logic [DIST_BITS-1:0] best_d [MAX_VERTICES];
        logic [NODE_BITS-1:0] parent [MAX_VERTICES];
        logic                 done   [MAX_VERTICES];
        logic [DIST_BITS:0]   sum;
        int                   pick;
        bit                   found;
        int unsigned          near;
        int unsigned          far;
        path_answer_t         ans;
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            best_d[v] = sssp_pkg::DIST_INF;
            parent[v] = '0;
            done[v]   = 1'b0;
        end
        if (src < live_vertices)
        begin
            best_d[src] = '0;
            parent[src] = src;
            for (int round = 0; round < live_vertices; round++)
            begin
                found = 1'b0;
                pick  = 0;
                for (int v = 0; v < live_vertices; v++)
                begin
                    if (!done[v] && best_d[v] != sssp_pkg::DIST_INF)
                    begin
                        if (!found || best_d[v] < best_d[pick] ||
                            (best_d[v] == best_d[pick] && parent[v] < parent[pick]))
                        begin
                            pick  = v;
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    break;
                done[pick] = 1'b1;
                for (int e = 0; e < edge_total; e++)
                begin
                    for (int side = 0; side < 2; side++)
                    begin
                        near = (side == 0) ? edge_list[e].a : edge_list[e].b;
                        far  = (side == 0) ? edge_list[e].b : edge_list[e].a;
                        if (near == pick && far < live_vertices && !done[far])
                        begin
                            sum = {1'b0, best_d[pick]} + (DIST_BITS + 1)'(edge_list[e].w);
                            if (sum > {1'b0, sssp_pkg::DIST_INF} - (DIST_BITS + 1)'(1))
                                sum = {1'b0, sssp_pkg::DIST_INF} - (DIST_BITS + 1)'(1);
                            if ({1'b0, best_d[far]} > sum)
                            begin
                                best_d[far] = sum[DIST_BITS-1:0];
                                parent[far] = NODE_BITS'(pick);
                            end
                        end
                    end
                end
            end
        end
        ans.overflow    = edge_dropped;
        ans.reachable   = src < live_vertices && dst < live_vertices
                          && best_d[dst] != sssp_pkg::DIST_INF;
        ans.distance    = ans.reachable ? best_d[dst] : sssp_pkg::DIST_INF;
        ans.predecessor = ans.reachable ? parent[dst] : '0;
        return ans;
    endfunction

    always @(posedge clk)
    begin
        path_answer_t           want;
        logic [NODE_BITS-1:0]   node_a;
        logic [NODE_BITS-1:0]   node_b;
        logic [WEIGHT_BITS-1:0] weight;
        logic [VC_BITS-1:0]     vcount;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answer_queue.size() == 0)
                begin
                    $error("unexpected result item %h", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    answered++;
                    if (want.reachable)
                        reached++;
                    if (want.overflow)
                        flagged++;
                    if (m_axis_tdata[23:0] !== want.distance)
                    begin
                        $error("distance expected %0d actual %0d",
                               want.distance, m_axis_tdata[23:0]);
                        fails++;
                    end
                    if (m_axis_tdata[24] !== want.reachable)
                    begin
                        $error("reachable expected %0d actual %0d",
                               want.reachable, m_axis_tdata[24]);
                        fails++;
                    end
                    if (m_axis_tdata[30:25] !== want.predecessor)
                    begin
                        $error("predecessor expected %0d actual %0d",
                               want.predecessor, m_axis_tdata[30:25]);
                        fails++;
                    end
                    if (m_axis_tdata[31] !== want.overflow)
                    begin
                        $error("overflow expected %0d actual %0d",
                               want.overflow, m_axis_tdata[31]);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                node_a = s_axis_tdata[5:0];
                node_b = s_axis_tdata[11:6];
                weight = s_axis_tdata[27:12];
                vcount = s_axis_tdata[34:28];
                case (s_axis_tuser)
                    sssp_pkg::CMD_CLEAR:
                    begin
                        if (vcount == 0)
                            live_vertices = 1;
                        else if (vcount > MAX_VERTICES)
                            live_vertices = MAX_VERTICES;
                        else
                            live_vertices = vcount;
                        edge_total   = 0;
                        edge_dropped = 1'b0;
                    end
                    sssp_pkg::CMD_ADD:
                    begin
                        if (weight != 0 && node_a < live_vertices && node_b < live_vertices)
                        begin
                            if (edge_total >= MAX_EDGES)
                                edge_dropped = 1'b1;
                            else
                            begin
                                edge_list[edge_total] = '{w: weight, b: node_b, a: node_a};
                                edge_total++;
                            end
                        end
                    end
                    sssp_pkg::CMD_SOLVE:
                        answer_queue = {answer_queue, shortest_path(node_a, node_b)};
                    default:
                    begin
                    end
                endcase
            end
            queued = answer_queue.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int CMD_BITS     = sssp_pkg::CMD_BITS;
    localparam int NODE_BITS    = sssp_pkg::NODE_BITS;
    localparam int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS;
    localparam int VC_BITS      = sssp_pkg::VC_BITS;
    localparam int MAX_VERTICES = sssp_pkg::MAX_VERTICES;
    localparam int MAX_EDGES    = sssp_pkg::MAX_EDGES;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_GOAL    = 1200;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // node_a, node_b, weight, vertex_count, zero pad
    logic [1:0]  s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // distance, reachable, predecessor, overflow

    int fail_count;
    int pending;
    int results_seen;
    int reached_seen;
    int overflow_seen;

    int items_sent  = 0;
    int solves_sent = 0;
    int cycle_count = 0;
    int send_quiet  = 0;
    int recv_quiet  = 0;
    int episode     = 0;
    int vc_pick;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    single_source_shortest_path_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sssp_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .reached_seen  (reached_seen),
        .overflow_seen (overflow_seen)
    );

    // idle cycles before the next item, with occasional runs of none
    function automatic int draw_wait(ref int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [NODE_BITS-1:0] pick_node(input int live, input bit clean);
        if (!clean && $urandom_range(0, 11) == 0)
            return NODE_BITS'($urandom_range(0, MAX_VERTICES - 1));
        return NODE_BITS'($urandom_range(0, live - 1));
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r <= 8)
            return WEIGHT_BITS'($urandom_range(1, 4));
        return WEIGHT_BITS'($urandom_range(1, 65535));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                                input logic [NODE_BITS-1:0] node_a,
                                input logic [NODE_BITS-1:0] node_b,
                                input logic [WEIGHT_BITS-1:0] weight,
                                input logic [VC_BITS-1:0] vcount);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {5'b0, vcount, weight, node_b, node_a};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
        if (cmd == sssp_pkg::CMD_SOLVE)
            solves_sent++;
    endtask

    // drop the input valid and hold until every expected result has come
    task automatic wait_for_answers();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic send_noise();
        send_command(CMD_UNUSED, NODE_BITS'($urandom), NODE_BITS'($urandom),
                     WEIGHT_BITS'($urandom), VC_BITS'($urandom));
    endtask

    // clear, then edges and solves mixed at random, with unused commands among them unless clean
    task automatic run_episode(input int vcount, input int edges, input int solves,
                               input bit clean);
        int live;
        int total_left;
        int solves_left;
        live = (vcount == 0) ? 1 : (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
        send_command(sssp_pkg::CMD_CLEAR, NODE_BITS'($urandom), NODE_BITS'($urandom),
                     WEIGHT_BITS'($urandom), VC_BITS'(vcount));
        solves_left = solves;
        total_left  = edges + solves;
        while (total_left > 0)
        begin
            if (!clean && $urandom_range(0, 29) == 0)
                send_noise();
            if ($urandom_range(1, total_left) <= solves_left)
            begin
                send_command(sssp_pkg::CMD_SOLVE, pick_node(live, clean),
                             pick_node(live, clean),
                             WEIGHT_BITS'($urandom), VC_BITS'($urandom));
                solves_left--;
            end
            else if (clean)
                send_command(sssp_pkg::CMD_ADD, pick_node(live, 1'b1), pick_node(live, 1'b1),
                             WEIGHT_BITS'($urandom_range(1, 65535)), VC_BITS'($urandom));
            else
                send_command(sssp_pkg::CMD_ADD, pick_node(live, 1'b0), pick_node(live, 1'b0),
                             pick_weight(), VC_BITS'($urandom));
            total_left--;
        end
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int stall;
            @(negedge clk);
            stall = draw_wait(recv_quiet);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = sssp_pkg::CMD_CLEAR;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // empty store after reset, unknown command, vertex count limits
        send_command(sssp_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd0, 6'd63, 16'd0, 7'd0);
        send_command(CMD_UNUSED, 6'd63, 6'd63, 16'hFFFF, 7'd127);
        send_command(sssp_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd1, 6'd0, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'd0, 7'd127);
        // heaviest edge, zero weight, self loop, equal-cost paths
        send_command(sssp_pkg::CMD_ADD, 6'd63, 6'd0, 16'hFFFF, 7'd0);
        send_command(sssp_pkg::CMD_ADD, 6'd0, 6'd1, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_ADD, 6'd5, 6'd5, 16'd7, 7'd0);
        send_command(sssp_pkg::CMD_ADD, 6'd0, 6'd1, 16'd1, 7'd0);
        send_command(sssp_pkg::CMD_ADD, 6'd1, 6'd2, 16'd1, 7'd0);
        send_command(sssp_pkg::CMD_ADD, 6'd0, 6'd2, 16'd2, 7'd0);
        send_command(sssp_pkg::CMD_ADD, 6'd2, 6'd63, 16'd3, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd0, 6'd2, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd0, 6'd63, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd63, 6'd1, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd5, 6'd5, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd0, 6'd5, 16'd0, 7'd0);
        // endpoints past the vertices in use
        send_command(sssp_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'd0, 7'd3);
        send_command(sssp_pkg::CMD_ADD, 6'd0, 6'd3, 16'd1, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd0, 6'd3, 16'd0, 7'd0);
        send_command(sssp_pkg::CMD_SOLVE, 6'd3, 6'd0, 16'd0, 7'd0);
        wait_for_answers();

        while (items_sent < ITEM_GOAL)
        begin
            if (episode == 4 || episode == 40)
                run_episode($urandom_range(2, 5), MAX_EDGES + $urandom_range(1, 12), 3, 1'b1);
            else if (episode == 15)
                run_episode(MAX_VERTICES, 150, 2, 1'b0);
            else if ($urandom_range(0, 9) == 0)
                run_episode($urandom_range(0, 127), $urandom_range(0, 16),
                            $urandom_range(1, 2), 1'b0);
            else
            begin
                vc_pick = $urandom_range(2, 12);
                run_episode(vc_pick, $urandom_range(0, 2 * vc_pick), $urandom_range(1, 6),
                            1'b0);
            end
            if (episode % 10 == 9)
                wait_for_answers();
            episode++;
        end

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("tb: %0d items over %0d graphs, %0d solves answered, %0d targets reached",
                 items_sent, episode + 3, results_seen, reached_seen);
        $display("tb: %0d answers reported a dropped edge", overflow_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
